FILE: rtl/core/mup_pkg.sv
package mup_pkg;

   localparam int VALUE_W     = 32;
   localparam int INDEX_W     = 16;
   localparam int WADDR_W     = 24;
   localparam int POOL_W      = 9;
   localparam int IN_DIM_W    = 13;
   localparam int OUT_DIM_W   = 14;
   localparam int PLANES_W    = 17;
   localparam int ROW_CNT_W   = 12;
   localparam int COL_CNT_W   = 12;
   localparam int PLANE_CNT_W = 16;
   // operand width of the shared multiply-add unit (output row or column span)
   localparam int SPAN_W      = 22;
   localparam int MAC_W       = SPAN_W + OUT_DIM_W + 1;
   localparam int PSIZE_W     = 2 * OUT_DIM_W;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int DIV_STEPS   = INDEX_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [ROW_CNT_W-1:0]   ROW_MAX   = '1;
   localparam logic [COL_CNT_W-1:0]   COL_MAX   = '1;
   localparam logic [PLANE_CNT_W-1:0] PLANE_MAX = '1;

   typedef enum logic [2:0] {
      REG_POOL_ROWS,
      REG_POOL_COLS,
      REG_IN_ROWS,
      REG_IN_COLS,
      REG_OUT_ROWS,
      REG_OUT_COLS,
      REG_PLANE_COUNT
   } csr_reg_type;

   typedef struct packed {
      logic [POOL_W-1:0]    pool_rows;
      logic [POOL_W-1:0]    pool_cols;
      logic [IN_DIM_W-1:0]  in_rows;
      logic [IN_DIM_W-1:0]  in_cols;
      logic [OUT_DIM_W-1:0] out_rows;
      logic [OUT_DIM_W-1:0] out_cols;
      logic [PLANES_W-1:0]  plane_count;
   } cfg_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [INDEX_W-1:0] quotient;
      logic [POOL_W-1:0]  remainder;
   } div_res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_ROW,
      ST_COL,
      ST_LOC,
      ST_PSZ,
      ST_FIN
   } seq_state_type;

endpackage

FILE: rtl/core/mup_chan_if.sv
interface mup_req_if;
   import mup_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] pooled_value;
   logic [INDEX_W-1:0] pool_index;

   modport source (output valid, pooled_value, pool_index, input ready);
   modport sink (input valid, pooled_value, pool_index, output ready);
endinterface

interface mup_rsp_if;
   import mup_pkg::*;

   logic               valid;
   logic               ready;
   logic [WADDR_W-1:0] write_address;
   logic [VALUE_W-1:0] written_value;
   logic               in_range;
   logic               last;

   modport source (output valid, write_address, written_value, in_range, last,
                   input ready);
   modport sink (input valid, write_address, written_value, in_range, last,
                 output ready);
endinterface

FILE: rtl/core/mup_csr.sv
module mup_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [mup_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [mup_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mup_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output mup_pkg::cfg_type                 cfg
);
   import mup_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_reg_type reg_sel;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_POOL_ROWS:   cfg_in.pool_rows   = csr_pwdata[POOL_W-1:0];
            REG_POOL_COLS:   cfg_in.pool_cols   = csr_pwdata[POOL_W-1:0];
            REG_IN_ROWS:     cfg_in.in_rows     = csr_pwdata[IN_DIM_W-1:0];
            REG_IN_COLS:     cfg_in.in_cols     = csr_pwdata[IN_DIM_W-1:0];
            REG_OUT_ROWS:    cfg_in.out_rows    = csr_pwdata[OUT_DIM_W-1:0];
            REG_OUT_COLS:    cfg_in.out_cols    = csr_pwdata[OUT_DIM_W-1:0];
            REG_PLANE_COUNT: cfg_in.plane_count = csr_pwdata[PLANES_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_POOL_ROWS:   csr_prdata = CSR_DATA_W'(cfg_ff.pool_rows);
         REG_POOL_COLS:   csr_prdata = CSR_DATA_W'(cfg_ff.pool_cols);
         REG_IN_ROWS:     csr_prdata = CSR_DATA_W'(cfg_ff.in_rows);
         REG_IN_COLS:     csr_prdata = CSR_DATA_W'(cfg_ff.in_cols);
         REG_OUT_ROWS:    csr_prdata = CSR_DATA_W'(cfg_ff.out_rows);
         REG_OUT_COLS:    csr_prdata = CSR_DATA_W'(cfg_ff.out_cols);
         REG_PLANE_COUNT: csr_prdata = CSR_DATA_W'(cfg_ff.plane_count);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pool_rows   <= POOL_W'(2);
         cfg_ff.pool_cols   <= POOL_W'(2);
         cfg_ff.in_rows     <= IN_DIM_W'(1);
         cfg_ff.in_cols     <= IN_DIM_W'(1);
         cfg_ff.out_rows    <= OUT_DIM_W'(2);
         cfg_ff.out_cols    <= OUT_DIM_W'(2);
         cfg_ff.plane_count <= PLANES_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/mup_div.sv
module mup_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mup_pkg::INDEX_W-1:0]   dividend,
   input  logic [mup_pkg::POOL_W-1:0]    divisor,
   output mup_pkg::div_res_type          res
);
   import mup_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [INDEX_W-1:0]   dvd_ff, dvd_in;
   logic [POOL_W-1:0]    dsr_ff, dsr_in;
   logic [POOL_W-1:0]    rem_ff, rem_in;
   logic [POOL_W:0]      trial;
   logic                 fits;

   // one quotient bit per cycle; quotient bits shift in behind the dividend
   assign trial = {rem_ff, dvd_ff[INDEX_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      dvd_in   = dvd_ff;
      dsr_in   = dsr_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         dvd_in   = dividend;
         // a zero window height divides as one
         dsr_in   = (divisor == '0) ? POOL_W'(1) : divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         rem_in   = fits ? POOL_W'(trial - {1'b0, dsr_ff}) : trial[POOL_W-1:0];
         dvd_in   = {dvd_ff[INDEX_W-2:0], fits};
         count_in = count_ff + DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign res.busy      = busy_ff;
   assign res.done      = done_ff;
   assign res.quotient  = dvd_ff;
   assign res.remainder = rem_ff;

endmodule

FILE: rtl/core/mup_mac.sv
module mup_mac (
   input  logic                            clock,
   input  logic                            en,
   input  logic [mup_pkg::SPAN_W-1:0]      op_a,
   input  logic [mup_pkg::OUT_DIM_W-1:0]   op_b,
   input  logic [mup_pkg::SPAN_W-1:0]      op_c,
   output logic [mup_pkg::MAC_W-1:0]       result
);
   import mup_pkg::*;

   logic [SPAN_W+OUT_DIM_W-1:0] prod;
   logic [MAC_W-1:0]            result_ff, result_in;

   assign prod      = op_a * op_b;
   assign result_in = en ? (MAC_W'(prod) + MAC_W'(op_c)) : result_ff;

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

FILE: rtl/core/max_unpool_scatter_address.sv
// Channel   Dir  Fields                                            Handshake
// req_chan  in   pooled_value[31:0], pool_index[15:0]              valid/ready
// rsp_chan  out  write_address[23:0], written_value[31:0],         valid/ready
//                in_range, last
// csr_*     in   APB registers 0..6 at byte address 4*i            psel/penable
//
// From acceptance to the output register an item is started, its pool_index
// is split by the radix-2 divider, it makes 4 passes through the shared
// multiply-add unit, and a last step forms the address and advances counters.
// req_chan.ready is high only while the sequencer idles; a result waiting
// in the output register does not block the next item, only its final cycle.
// Synchronous reset clears sequencer, counters, plane base and output valid.
module max_unpool_scatter_address #(
   parameter int ADDR_BITS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   mup_req_if.sink                          req_chan,
   mup_rsp_if.source                        rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [mup_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [mup_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mup_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import mup_pkg::*;

   localparam int ADDR_EXT_W = ADDR_BITS + WADDR_W;
   localparam int BASE_SUM_W = ADDR_BITS + PSIZE_W;

   cfg_type       cfg;
   div_res_type   div_res;
   seq_state_type state_ff, state_in;

   logic                   accept;
   logic                   div_start;
   logic                   mac_en;
   logic [SPAN_W-1:0]      mac_a, mac_c;
   logic [OUT_DIM_W-1:0]   mac_b;
   logic [MAC_W-1:0]       mac_result;

   logic [VALUE_W-1:0]     value_ff, value_in;
   logic [SPAN_W-1:0]      out_row_ff, out_row_in;
   logic [MAC_W-1:0]       local_ff, local_in;

   logic [ROW_CNT_W-1:0]   row_ff, row_in;
   logic [COL_CNT_W-1:0]   col_ff, col_in;
   logic [PLANE_CNT_W-1:0] plane_ff, plane_in;
   logic [ADDR_BITS-1:0]   plane_base_ff, plane_base_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic [VALUE_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                   rsp_range_ff, rsp_range_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   load_out;
   logic [PSIZE_W-1:0]     plane_size;
   logic [ADDR_BITS-1:0]   addr_sum;
   logic [ADDR_EXT_W-1:0]  addr_ext;
   logic                   row_wrap, col_wrap, plane_wrap, is_last;

   mup_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mup_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_chan.pool_index),
      .divisor  (cfg.pool_rows),
      .res      (div_res)
   );

   mup_mac u_mac (
      .clock  (clock),
      .en     (mac_en),
      .op_a   (mac_a),
      .op_b   (mac_b),
      .op_c   (mac_c),
      .result (mac_result)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign div_start      = accept;

   // final step: the product of the last pass is the plane size
   assign plane_size = mac_result[PSIZE_W-1:0];
   assign addr_sum   = plane_base_ff + local_ff[ADDR_BITS-1:0];
   assign addr_ext   = ADDR_EXT_W'(addr_sum);
   assign load_out   = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_chan.ready);

   assign row_wrap   = (({1'b0, row_ff} + (ROW_CNT_W+1)'(1)) >= cfg.in_rows)
                       || (row_ff == ROW_MAX);
   assign col_wrap   = (({1'b0, col_ff} + (COL_CNT_W+1)'(1)) >= cfg.in_cols)
                       || (col_ff == COL_MAX);
   assign plane_wrap = (({1'b0, plane_ff} + (PLANE_CNT_W+1)'(1)) >= cfg.plane_count)
                       || (plane_ff == PLANE_MAX);
   assign is_last    = row_wrap && col_wrap && plane_wrap;

   // sequencer: divide, then four passes through the multiply-add unit
   always_comb begin
      state_in = state_ff;
      mac_en   = 1'b0;
      mac_a    = '0;
      mac_b    = '0;
      mac_c    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_res.done) state_in = ST_ROW;
         end
         ST_ROW: begin
            mac_en   = 1'b1;
            mac_a    = SPAN_W'(row_ff);
            mac_b    = OUT_DIM_W'(cfg.pool_rows);
            mac_c    = SPAN_W'(div_res.remainder);
            state_in = ST_COL;
         end
         ST_COL: begin
            mac_en   = 1'b1;
            mac_a    = SPAN_W'(col_ff);
            mac_b    = OUT_DIM_W'(cfg.pool_cols);
            mac_c    = SPAN_W'(div_res.quotient);
            state_in = ST_LOC;
         end
         ST_LOC: begin
            mac_en   = 1'b1;
            mac_a    = mac_result[SPAN_W-1:0];
            mac_b    = cfg.out_rows;
            mac_c    = out_row_ff;
            state_in = ST_PSZ;
         end
         ST_PSZ: begin
            mac_en   = 1'b1;
            mac_a    = SPAN_W'(cfg.out_cols);
            mac_b    = cfg.out_rows;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (load_out) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      value_in   = accept ? req_chan.pooled_value : value_ff;
      out_row_in = (state_ff == ST_COL) ? mac_result[SPAN_W-1:0] : out_row_ff;
      local_in   = (state_ff == ST_PSZ) ? mac_result : local_ff;
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      out_row_ff <= out_row_in;
      local_ff   <= local_in;
   end

   // advance row, then column, then plane
   always_comb begin
      row_in        = row_ff;
      col_in        = col_ff;
      plane_in      = plane_ff;
      plane_base_in = plane_base_ff;
      if (load_out) begin
         if (!row_wrap) begin
            row_in = row_ff + ROW_CNT_W'(1);
         end else begin
            row_in = '0;
            if (!col_wrap) begin
               col_in = col_ff + COL_CNT_W'(1);
            end else begin
               col_in = '0;
               if (!plane_wrap) begin
                  plane_in      = plane_ff + PLANE_CNT_W'(1);
                  plane_base_in = ADDR_BITS'(BASE_SUM_W'(plane_base_ff)
                                             + BASE_SUM_W'(plane_size));
               end else begin
                  plane_in      = '0;
                  plane_base_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff        <= '0;
         col_ff        <= '0;
         plane_ff      <= '0;
         plane_base_ff <= '0;
      end else begin
         row_ff        <= row_in;
         col_ff        <= col_in;
         plane_ff      <= plane_in;
         plane_base_ff <= plane_base_in;
      end
   end

   // output register: load on the final step, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_value_in = rsp_value_ff;
      rsp_range_in = rsp_range_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_chan.ready) rsp_valid_in = 1'b0;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = addr_ext[WADDR_W-1:0];
         rsp_value_in = value_ff;
         rsp_range_in = local_ff < MAC_W'(plane_size);
         rsp_last_in  = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff  <= rsp_addr_in;
      rsp_value_ff <= rsp_value_in;
      rsp_range_ff <= rsp_range_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.write_address = rsp_addr_ff;
   assign rsp_chan.written_value = rsp_value_ff;
   assign rsp_chan.in_range      = rsp_range_ff;
   assign rsp_chan.last          = rsp_last_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide step");

   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !div_res.busy)
      else $error("divider busy while the sequencer idles");

   a_hold_full_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rsp_valid_ff && !rsp_chan.ready) |=> state_ff == ST_FIN)
      else $error("result overwrote a waiting item");

   a_last_rewinds: assert property (@(posedge clock) disable iff (reset)
      (load_out && is_last) |=> (row_ff == '0 && col_ff == '0 && plane_ff == '0
                                 && plane_base_ff == '0))
      else $error("counters not cleared after the final element");

   a_counters_move_on_load: assert property (@(posedge clock) disable iff (reset)
      !load_out |=> ($stable(row_ff) && $stable(col_ff) && $stable(plane_ff)))
      else $error("position counters moved without a result");

endmodule
